### rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants of the frame rate meter.
// ----------------------------------------------------------------------------
package frm_pkg;

	localparam int TIME_BITS  = 48;
	localparam int CFG_BITS   = 24;
	localparam int COUNT_BITS = 32;
	localparam int RATE_BITS  = 32;
	localparam int SCALE_BITS = 28;
	localparam int NUM_BITS   = COUNT_BITS + SCALE_BITS;
	localparam int ITER_BITS  = $clog2(RATE_BITS);

	// 1e6 us per second, times 256 for Q24.8
	localparam logic [SCALE_BITS-1:0] RATE_SCALE = SCALE_BITS'(256000000);

	localparam logic [CFG_BITS-1:0] MAX_DELTA_RESET = CFG_BITS'(100000);
	localparam logic [CFG_BITS-1:0] WINDOW_RESET    = CFG_BITS'(1000000);

	localparam logic CFG_MAX_DELTA = 1'b0;
	localparam logic CFG_WINDOW    = 1'b1;

	typedef enum logic [1:0] {
		ACT_RESTART = 2'd0,
		ACT_MARK    = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic mul;
		logic chk;
		logic div_step;
		logic emit;
	} frm_cmd_t;

	typedef struct packed {
		logic need_div;
		logic sat;
	} frm_sts_t;

endpackage

### rtl/frm_datapath.sv
// ----------------------------------------------------------------------------
// frm_datapath
// Timing state, configuration, rate multiplier, radix-2 divider, output regs.
// ----------------------------------------------------------------------------
module frm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [frm_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic [1:0]                    action,
	input  logic [frm_pkg::TIME_BITS-1:0] now_us,
	input  frm_pkg::frm_cmd_t             cmd,
	output frm_pkg::frm_sts_t             sts,
	output logic [23:0]                   delta_us,
	output logic [31:0]                   frame_total,
	output logic [31:0]                   rate_q8,
	output logic                          window_closed
);

	localparam int TB = frm_pkg::TIME_BITS;
	localparam int RB = frm_pkg::RATE_BITS;

	logic [frm_pkg::CFG_BITS-1:0] max_delta_q;
	logic [frm_pkg::CFG_BITS-1:0] window_q;

	logic [TB-1:0] last_frame_q;
	logic [TB-1:0] win_start_q;
	logic [31:0]   total_q;
	logic [31:0]   win_count_q;
	logic [31:0]   held_rate_q;
	logic [23:0]   held_delta_q;

	frm_pkg::action_t act_q;
	logic [TB-1:0]    now_q;

	logic [frm_pkg::COUNT_BITS-1:0] cnt_op_q;
	logic [TB-1:0]                  div_q;
	logic [frm_pkg::NUM_BITS-1:0]   num_q;
	logic [TB-1:0]                  rem_q;
	logic [RB-1:0]                  quo_q;
	logic [RB-1:0]                  res_rate_q;
	logic                           use_div_q;
	logic                           closed_q;

	logic [TB-1:0] dt;
	logic [TB-1:0] span;
	logic [TB-1:0] win;
	logic [TB-1:0] max_ext;
	logic [23:0]   dt_clamped;
	logic          close_win;
	logic [TB-1:0] num_hi;
	logic [TB:0]   rem_sh;
	logic [TB:0]   rem_diff;
	logic          rem_ge;

	always_comb begin
		dt         = now_q - last_frame_q;
		span       = now_q - win_start_q;
		win        = (window_q == '0) ? TB'(1) : TB'(window_q);
		max_ext    = TB'(max_delta_q);
		dt_clamped = (dt > max_ext) ? max_delta_q : dt[23:0];
		close_win  = (span >= win);
		case (act_q)
			frm_pkg::ACT_MARK:  sts.need_div = close_win;
			frm_pkg::ACT_QUERY: sts.need_div = (total_q != '0) && (span != '0);
			default:            sts.need_div = 1'b0;
		endcase
		num_hi   = TB'(num_q[frm_pkg::NUM_BITS-1:RB]);
		// quotient fits 32 bits only if the upper numerator part is below the divisor
		sts.sat  = (num_hi >= div_q);
		rem_sh   = {rem_q, quo_q[RB-1]};
		rem_diff = rem_sh - {1'b0, div_q};
		rem_ge   = (rem_sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delta_q <= frm_pkg::MAX_DELTA_RESET;
			window_q    <= frm_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				frm_pkg::CFG_MAX_DELTA: max_delta_q <= cfg_data;
				frm_pkg::CFG_WINDOW:    window_q    <= cfg_data;
				default:                ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_frame_q <= '0;
			win_start_q  <= '0;
			total_q      <= '0;
			win_count_q  <= '0;
			held_rate_q  <= '0;
			held_delta_q <= '0;
		end else if (cmd.eval) begin
			case (act_q)
				frm_pkg::ACT_RESTART: begin
					last_frame_q <= now_q;
					win_start_q  <= now_q;
					total_q      <= '0;
					win_count_q  <= '0;
					held_rate_q  <= '0;
					held_delta_q <= '0;
				end
				frm_pkg::ACT_MARK: begin
					last_frame_q <= now_q;
					held_delta_q <= dt_clamped;
					total_q      <= total_q + 32'd1;
					if (close_win) begin
						win_count_q <= '0;
						win_start_q <= now_q;
					end else begin
						win_count_q <= win_count_q + 32'd1;
					end
				end
				default: ;
			endcase
		end else if (cmd.emit && use_div_q && closed_q) begin
			held_rate_q <= quo_q;
		end
	end

	// payload, arithmetic and output registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= frm_pkg::action_t'(action);
			now_q <= now_us;
		end
		if (cmd.eval) begin
			use_div_q <= sts.need_div;
			div_q     <= span;
			closed_q  <= (act_q == frm_pkg::ACT_MARK) && close_win;
			cnt_op_q  <= (act_q == frm_pkg::ACT_MARK) ? win_count_q + 32'd1 : win_count_q;
			case (act_q)
				frm_pkg::ACT_RESTART: res_rate_q <= '0;
				frm_pkg::ACT_QUERY:   res_rate_q <= '0;
				default:              res_rate_q <= held_rate_q;
			endcase
		end
		if (cmd.mul) begin
			num_q <= frm_pkg::NUM_BITS'(cnt_op_q) * frm_pkg::NUM_BITS'(frm_pkg::RATE_SCALE);
		end
		if (cmd.chk) begin
			if (sts.sat) begin
				quo_q <= '1;
			end else begin
				rem_q <= num_hi;
				quo_q <= num_q[RB-1:0];
			end
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[TB-1:0] : rem_sh[TB-1:0];
			quo_q <= {quo_q[RB-2:0], rem_ge};
		end
		if (cmd.emit) begin
			delta_us      <= held_delta_q;
			frame_total   <= total_q;
			rate_q8       <= use_div_q ? quo_q : res_rate_q;
			window_closed <= closed_q;
		end
	end

endmodule

### rtl/frm_ctrl.sv
// ----------------------------------------------------------------------------
// frm_ctrl
// Sequencer: item intake, multiply, saturation check, division, result load.
// ----------------------------------------------------------------------------
module frm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  frm_pkg::frm_sts_t sts,
	output frm_pkg::frm_cmd_t cmd
);

	frm_pkg::state_t               state_q;
	frm_pkg::state_t               state_nx;
	logic [frm_pkg::ITER_BITS-1:0] iter_q;
	logic                          out_free;
	logic                          iter_last;

	assign out_free  = !out_valid || !out_stall;
	assign iter_last = (iter_q == frm_pkg::ITER_BITS'(frm_pkg::RATE_BITS - 1));
	assign in_stall  = (state_q != frm_pkg::ST_IDLE);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			frm_pkg::ST_IDLE: if (in_valid) state_nx = frm_pkg::ST_EVAL;
			frm_pkg::ST_EVAL: state_nx = sts.need_div ? frm_pkg::ST_MUL : frm_pkg::ST_EMIT;
			frm_pkg::ST_MUL:  state_nx = frm_pkg::ST_CHK;
			frm_pkg::ST_CHK:  state_nx = sts.sat ? frm_pkg::ST_EMIT : frm_pkg::ST_DIV;
			frm_pkg::ST_DIV:  if (iter_last) state_nx = frm_pkg::ST_EMIT;
			frm_pkg::ST_EMIT: if (out_free) state_nx = frm_pkg::ST_IDLE;
			default:          state_nx = frm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == frm_pkg::ST_IDLE) && in_valid;
		cmd.eval     = (state_q == frm_pkg::ST_EVAL);
		cmd.mul      = (state_q == frm_pkg::ST_MUL);
		cmd.chk      = (state_q == frm_pkg::ST_CHK);
		cmd.div_step = (state_q == frm_pkg::ST_DIV);
		cmd.emit     = (state_q == frm_pkg::ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= frm_pkg::ST_IDLE;
			iter_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_step) begin
				iter_q <= iter_q + 1'b1;
			end else begin
				iter_q <= '0;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == frm_pkg::ST_EVAL)
		else $error("accepted item did not enter evaluation");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid && state_q == frm_pkg::ST_IDLE)
		else $error("result load did not show a valid result");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frm_pkg::ST_DIV && iter_last) |=> state_q == frm_pkg::ST_EMIT)
		else $error("divider ran past its last step");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == frm_pkg::ST_EMIT)
		else $error("result appeared outside the load state");

endmodule

### rtl/frame_rate_meter_core.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_core
// Frame interval and frame rate measurement on microsecond timestamps.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries action and now_us; action 0
// restarts, 1 marks a frame, 2 queries the live rate. Every item gives one
// result item on the output channel (out_valid/out_stall): clamped delta,
// frame total, Q24.8 rate and a window-closed flag.
// Items are taken one at a time. Restart, plain frame marks and queries that
// need no rate go from evaluation straight to the result load; items that
// compute a rate pass through the multiplier and the saturation check and
// then the 32-step radix-2 divider, which a saturated rate skips.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the block finishes the next item and holds
// it until the output register frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// must make them only while the block is idle; the block does not enforce it.
// Reset clears the frame counts and stored times and loads the default register values.
// ----------------------------------------------------------------------------
module frame_rate_meter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [frm_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [frm_pkg::TIME_BITS-1:0] now_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [23:0]                   delta_us,
	output logic [31:0]                   frame_total,
	output logic [31:0]                   rate_q8,
	output logic                          window_closed
);

	frm_pkg::frm_cmd_t cmd;
	frm_pkg::frm_sts_t sts;

	frm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	frm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.now_us        (now_us),
		.cmd           (cmd),
		.sts           (sts),
		.delta_us      (delta_us),
		.frame_total   (frame_total),
		.rate_q8       (rate_q8),
		.window_closed (window_closed)
	);

endmodule

### verif/tb_frame_rate_meter_core.sv
// ----------------------------------------------------------------------------
// tb_frame_rate_meter_core
// Self-checking bench for the frame rate meter core.
// ----------------------------------------------------------------------------
// A tracker mirrors the counts, the window and the held values of the block.
// For every accepted input item it queues the expected report, and it checks
// each accepted output item against the oldest one. A short directed opening
// covers restart, query, unused action, clamping, wrap, zero window and rate
// saturation. Random phases under several register settings follow. Both
// channels idle in bursts except in the last phase.
// ----------------------------------------------------------------------------
module tb_frame_rate_meter_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		bit [23:0] delta;
		bit [31:0] total;
		bit [31:0] rate;
		bit        closed;
	} report_t;

	class rate_tracker;
		bit [23:0]   max_delta;
		bit [23:0]   window_len;
		bit [47:0]   last_frame;
		bit [47:0]   win_start;
		bit [31:0]   frames;
		bit [31:0]   win_frames;
		bit [31:0]   held_rate;
		bit [23:0]   held_delta;
		report_t     pending[$];
		int unsigned errors;
		int unsigned items;
		int unsigned reports;
		int unsigned latches;
		int unsigned settings;

		function new();
			max_delta  = frm_pkg::MAX_DELTA_RESET;
			window_len = frm_pkg::WINDOW_RESET;
			last_frame = '0;
			win_start  = '0;
			frames     = '0;
			win_frames = '0;
			held_rate  = '0;
			held_delta = '0;
		endfunction

		static function bit [31:0] q8_rate(bit [31:0] cnt, bit [47:0] span);
			bit [63:0] q;
			if (span == 0)
				return '0;
			q = (64'(cnt) * 64'd256000000) / 64'(span);
			return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		endfunction

		function void set_regs(bit [23:0] md, bit [23:0] win);
			max_delta  = md;
			window_len = win;
			settings++;
		endfunction

		function void take_item(bit [1:0] act, bit [47:0] t);
			report_t   r;
			bit [47:0] dt;
			bit [47:0] span;
			bit [23:0] win;
			r.closed = 1'b0;
			r.rate   = held_rate;
			case (act)
				frm_pkg::ACT_RESTART: begin
					last_frame = t;
					win_start  = t;
					frames     = '0;
					win_frames = '0;
					held_rate  = '0;
					held_delta = '0;
					r.rate     = '0;
				end
				frm_pkg::ACT_MARK: begin
					dt         = t - last_frame;
					last_frame = t;
					held_delta = (dt > 48'(max_delta)) ? max_delta : dt[23:0];
					frames++;
					win_frames++;
					span = t - win_start;
					win  = (window_len == 0) ? 24'd1 : window_len;
					if (span >= 48'(win)) begin
						held_rate  = q8_rate(win_frames, span);
						win_frames = '0;
						win_start  = t;
						r.closed   = 1'b1;
						latches++;
					end
					r.rate = held_rate;
				end
				frm_pkg::ACT_QUERY: begin
					span   = t - win_start;
					r.rate = (frames == 0 || span == 0) ? 32'd0 : q8_rate(win_frames, span);
				end
				default: ;
			endcase
			r.delta = held_delta;
			r.total = frames;
			pending.push_back(r);
			items++;
		endfunction

		function void check_item(logic [23:0] d, logic [31:0] tot, logic [31:0] rate,
			logic closed);
			report_t e;
			if (pending.size() == 0) begin
				$error("output item with no input item outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			reports++;
			if (d !== e.delta) begin
				$error("delta_us expected %0d actual %0d", e.delta, d);
				errors++;
			end
			if (tot !== e.total) begin
				$error("frame_total expected %0d actual %0d", e.total, tot);
				errors++;
			end
			if (rate !== e.rate) begin
				$error("rate_q8 expected 0x%08h actual 0x%08h", e.rate, rate);
				errors++;
			end
			if (closed !== e.closed) begin
				$error("window_closed expected %0d actual %0d", e.closed, closed);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_index;
	logic [frm_pkg::CFG_BITS-1:0]   cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [1:0]                     action;
	logic [frm_pkg::TIME_BITS-1:0]  now_us;
	logic                           out_valid;
	logic                           out_stall;
	logic [23:0]                    delta_us;
	logic [31:0]                    frame_total;
	logic [31:0]                    rate_q8;
	logic                           window_closed;

	rate_tracker tracker = new();
	bit          calm;
	bit [47:0]   clock_us;

	frame_rate_meter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.now_us        (now_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.delta_us      (delta_us),
		.frame_total   (frame_total),
		.rate_q8       (rate_q8),
		.window_closed (window_closed)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && !out_stall)
			tracker.check_item(delta_us, frame_total, rate_q8, window_closed);
	end

	// receiver stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && !calm && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL frame_rate_meter_core");
		$finish;
	end

	// valid stays high from here until the caller lowers it
	task automatic send_item(input bit [1:0] act, input bit [47:0] t);
		in_valid <= 1'b1;
		action   <= act;
		now_us   <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_item(act, t);
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_regs(input bit [23:0] md, input bit [23:0] win);
		cfg_we    <= 1'b1;
		cfg_index <= frm_pkg::CFG_MAX_DELTA;
		cfg_data  <= md;
		@(posedge clk);
		cfg_index <= frm_pkg::CFG_WINDOW;
		cfg_data  <= win;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_regs(md, win);
	endtask

	function automatic bit [47:0] frame_gap();
		case ($urandom_range(0, 9))
			0:          return '0;
			1, 2:       return 48'($urandom_range(1, 2000));
			3, 4, 5, 6: return 48'($urandom_range(4000, 40000));
			7, 8:       return 48'($urandom_range(50000, 300000));
			default: begin
				if ($urandom_range(0, 19) == 0)
					return 48'({$urandom(), $urandom()});
				return 48'($urandom_range(1, 3000000));
			end
		endcase
	endfunction

	// mostly well-formed timing with random gaps; some noise with arbitrary
	// action codes and timestamps
	task automatic random_item();
		bit [1:0]  act;
		bit [47:0] t;
		int        pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			act = 2'($urandom_range(0, 3));
			t   = 48'({$urandom(), $urandom()});
		end else begin
			if (pick < 15)
				act = frm_pkg::ACT_RESTART;
			else if (pick < 78)
				act = frm_pkg::ACT_MARK;
			else
				act = frm_pkg::ACT_QUERY;
			t = clock_us + frame_gap();
		end
		clock_us = t;
		send_item(act, t);
	endtask

	initial begin
		bit [23:0] md;
		bit [23:0] win;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= frm_pkg::CFG_MAX_DELTA;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		action    <= frm_pkg::ACT_RESTART;
		now_us    <= '0;
		out_stall <= 1'b0;
		calm      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: no frames yet, unused code, restart, clamp, latch
		send_item(frm_pkg::ACT_QUERY, 48'd0);
		send_item(frm_pkg::ACT_NONE, 48'd5);
		send_item(frm_pkg::ACT_RESTART, 48'd1000);
		send_item(frm_pkg::ACT_QUERY, 48'd1000);
		send_item(frm_pkg::ACT_MARK, 48'd17667);
		send_item(frm_pkg::ACT_MARK, 48'd500000);
		send_item(frm_pkg::ACT_QUERY, 48'd600000);
		send_item(frm_pkg::ACT_MARK, 48'd1001000);
		send_item(frm_pkg::ACT_NONE, 48'hFFFF_FFFF_FFFF);
		// timestamp wrap
		send_item(frm_pkg::ACT_RESTART, 48'hFFFF_FFFF_FFF0);
		send_item(frm_pkg::ACT_MARK, 48'h10);
		drain(40);

		// zero window acts as one, zero clamp
		write_regs(24'd0, 24'd0);
		send_item(frm_pkg::ACT_MARK, 48'h11);
		drain(40);

		// pile frames into one microsecond to overflow the rate
		write_regs(24'hFF_FFFF, 24'hFF_FFFF);
		repeat (17) send_item(frm_pkg::ACT_MARK, 48'h11);
		send_item(frm_pkg::ACT_QUERY, 48'h12);
		drain(40);
		write_regs(24'hFF_FFFF, 24'd1);
		send_item(frm_pkg::ACT_MARK, 48'h12);
		drain(40);
		clock_us = 48'h12;

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin md = 24'd100000;   win = 24'd1000000;  end
				1: begin md = 24'hFF_FFFF;  win = 24'd20000;    end
				2: begin md = 24'd0;        win = 24'd0;        end
				3: begin
					md  = 24'($urandom_range(0, 24'hFF_FFFF));
					win = 24'($urandom_range(1, 100000));
				end
				4: begin md = 24'd5000;     win = 24'hFF_FFFF;  end
				default: begin
					md  = 24'($urandom_range(0, 24'hFF_FFFF));
					win = 24'($urandom_range(1, 24'hFF_FFFF));
				end
			endcase
			write_regs(md, win);
			calm = (phase == 5);
			for (int n = 0; n < 175; n++) begin
				random_item();
				if (phase == 2 && n == 90)
					drain(0);
				else
					sender_gap();
			end
			drain(40);
		end

		$display("%0d items sent, %0d results checked, %0d windows latched",
			tracker.items, tracker.reports, tracker.latches);
		$display("%0d register settings, with idle bursts on both channels",
			tracker.settings);
		if (tracker.errors == 0)
			$display("PASS frame_rate_meter_core");
		else
			$display("FAIL frame_rate_meter_core");
		$finish;
	end

endmodule
